>>> hdl/sfid_pkg.sv
package sfid_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int OUT_COUNT_WIDTH     = 32;

   localparam logic [7:0]  SYNC_FIRST_RESET    = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND_RESET   = 8'h5A;
   localparam logic [7:0]  ACCEPTED_TYPE_RESET = 8'h01;
   localparam logic [7:0]  MIN_LENGTH_RESET    = 8'd3;
   localparam logic [7:0]  MAX_LENGTH_RESET    = 8'd32;
   localparam logic [15:0] SEQ_HALF_WINDOW     = 16'h8000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_FIRST    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_SECOND   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEPTED_TYPE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_LENGTH    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LENGTH    = 3'd4;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_TYPE    = 3'd2,
      PH_SEQ_LO  = 3'd3,
      PH_SEQ_HI  = 3'd4,
      PH_LENGTH  = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_CHECK   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_NEW   = 3'd0,
      ST_STALE = 3'd1,
      ST_CSUM  = 3'd2,
      ST_TYPE  = 3'd3,
      ST_LONG  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] accepted_type;
      logic [7:0] min_length;
      logic [7:0] max_length;
   } cfg_type;

   // Frame end event from the parser to the judge.
   typedef struct packed {
      logic        valid;
      logic        over_limit;
      logic        sum_ok;
      logic [7:0]  frame_type;
      logic [15:0] frame_seq;
      logic [7:0]  payload_len;
      logic [7:0]  first_payload;
   } frame_end_type;

   typedef struct packed {
      status_type                 status;
      logic [7:0]                 frame_type;
      logic [15:0]                frame_seq;
      logic [7:0]                 payload_len;
      logic [7:0]                 control_byte;
      logic [OUT_COUNT_WIDTH-1:0] good_count;
      logic [OUT_COUNT_WIDTH-1:0] error_count;
   } result_type;

endpackage

>>> hdl/sfid_parser.sv
module sfid_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             data_byte,
   input  sfid_pkg::cfg_type      cfg,
   output sfid_pkg::frame_end_type frame_end
);
   import sfid_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  sum_add;
   logic [7:0]  index_inc;
   logic        over_limit;

   assign sum_add    = sum_ff + data_byte;
   assign index_inc  = index_ff + 8'd1;
   assign over_limit = data_byte > cfg.max_length;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      type_in  = type_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      index_in = index_ff;
      first_in = first_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (data_byte == cfg.sync_first) begin
               sum_in   = data_byte;
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (data_byte == cfg.sync_second) begin
               sum_in   = sum_add;
               phase_in = PH_TYPE;
            end else if (data_byte == cfg.sync_first) begin
               sum_in   = data_byte;
               phase_in = PH_SYNC2;
            end else begin
               sum_in   = 8'd0;
               phase_in = PH_HUNT;
            end
         end
         PH_TYPE: begin
            type_in  = data_byte;
            sum_in   = sum_add;
            phase_in = PH_SEQ_LO;
         end
         PH_SEQ_LO: begin
            seq_in   = {8'd0, data_byte};
            sum_in   = sum_add;
            phase_in = PH_SEQ_HI;
         end
         PH_SEQ_HI: begin
            seq_in   = {data_byte, seq_ff[7:0]};
            sum_in   = sum_add;
            phase_in = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (over_limit) begin
               phase_in = PH_HUNT;
               sum_in   = 8'd0;
               type_in  = 8'd0;
               seq_in   = 16'd0;
               len_in   = 8'd0;
               index_in = 8'd0;
               first_in = 8'd0;
            end else begin
               len_in   = data_byte;
               index_in = 8'd0;
               sum_in   = sum_add;
               phase_in = (data_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (index_ff == 8'd0) begin
               first_in = data_byte;
            end
            index_in = index_inc;
            sum_in   = sum_add;
            if (index_inc >= len_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            phase_in = PH_HUNT;
            sum_in   = 8'd0;
            type_in  = 8'd0;
            seq_in   = 16'd0;
            len_in   = 8'd0;
            index_in = 8'd0;
            first_in = 8'd0;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // Outputs
   always_comb begin
      frame_end               = '0;
      frame_end.frame_type    = type_ff;
      frame_end.frame_seq     = seq_ff;
      frame_end.payload_len   = len_ff;
      frame_end.first_payload = first_ff;
      frame_end.sum_ok        = (sum_add == 8'd0);
      if (take && phase_ff == PH_LENGTH && over_limit) begin
         frame_end.valid       = 1'b1;
         frame_end.over_limit  = 1'b1;
         frame_end.payload_len = data_byte;
      end else if (take && phase_ff == PH_CHECK) begin
         frame_end.valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= '0;
         type_ff  <= '0;
         seq_ff   <= '0;
         len_ff   <= '0;
         index_ff <= '0;
         first_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         type_ff  <= type_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         index_ff <= index_in;
         first_ff <= first_in;
      end
   end

endmodule

>>> hdl/sfid_judge.sv
module sfid_judge #(
   parameter int COUNT_WIDTH = sfid_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sfid_pkg::cfg_type       cfg,
   input  sfid_pkg::frame_end_type frame_end,
   output logic                    result_valid,
   output sfid_pkg::result_type    result
);
   import sfid_pkg::*;

   logic [15:0]            last_seq_ff, last_seq_in;
   logic [7:0]             control_ff, control_in;
   logic [COUNT_WIDTH-1:0] good_ff, good_in;
   logic [COUNT_WIDTH-1:0] bad_ff, bad_in;
   logic [15:0]            seq_diff;
   logic                   newer;
   logic [COUNT_WIDTH-1:0] good_inc;
   logic [COUNT_WIDTH-1:0] bad_inc;
   status_type             status;

   assign seq_diff = frame_end.frame_seq - last_seq_ff;
   assign newer    = (seq_diff < SEQ_HALF_WINDOW) && (seq_diff != 16'd0);
   assign good_inc = (good_ff == '1) ? good_ff : good_ff + COUNT_WIDTH'(1);
   assign bad_inc  = (bad_ff == '1) ? bad_ff : bad_ff + COUNT_WIDTH'(1);

   always_comb begin
      last_seq_in = last_seq_ff;
      control_in  = control_ff;
      good_in     = good_ff;
      bad_in      = bad_ff;
      priority if (frame_end.over_limit) begin
         status = ST_LONG;
         bad_in = bad_inc;
      end else if (!frame_end.sum_ok) begin
         status = ST_CSUM;
         bad_in = bad_inc;
      end else if (frame_end.frame_type != cfg.accepted_type ||
                   frame_end.payload_len < cfg.min_length) begin
         status = ST_TYPE;
         bad_in = bad_inc;
      end else if (newer || good_ff == '0) begin
         status      = ST_NEW;
         last_seq_in = frame_end.frame_seq;
         control_in  = frame_end.first_payload;
         good_in     = good_inc;
      end else begin
         status = ST_STALE;
      end
   end

   assign result_valid        = frame_end.valid;
   assign result.status       = status;
   assign result.frame_type   = frame_end.frame_type;
   assign result.frame_seq    = frame_end.frame_seq;
   assign result.payload_len  = frame_end.payload_len;
   assign result.control_byte = control_in;
   assign result.good_count   = OUT_COUNT_WIDTH'(good_in);
   assign result.error_count  = OUT_COUNT_WIDTH'(bad_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
         control_ff  <= '0;
         good_ff     <= '0;
         bad_ff      <= '0;
      end else if (frame_end.valid) begin
         last_seq_ff <= last_seq_in;
         control_ff  <= control_in;
         good_ff     <= good_in;
         bad_ff      <= bad_in;
      end
   end

endmodule

>>> hdl/sfid_outq.sv
module sfid_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfid_pkg::result_type push_data,
   input  logic                 pop_stall,
   output logic                 head_valid,
   output sfid_pkg::result_type head_data,
   output logic                 full
);
   import sfid_pkg::*;

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = head_valid_ff && !pop_stall;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign head_valid = head_valid_ff;
   assign head_data  = head_ff;
   assign full       = skid_valid_ff;

endmodule

>>> hdl/sync_framed_input_deframer.sv
// Two-byte sync frame deframer. Feed one received stream byte per item on
// the req_ channel; one item is taken every clock while req_stall is
// low. The block hunts for sync_first then sync_second (a repeated first
// sync byte restarts the frame), then collects type, little-endian 16-bit
// sequence, length, payload and a check byte that must bring the 8-bit sum
// of all frame bytes to zero. Each frame end (length over max_length, or
// the check byte) gives one rsp_ item with status, header fields, the
// latest control byte and saturating good/error counts; all other bytes
// give none. The result is registered into the output buffer as the byte
// that ends the frame is taken. Results pass through a two-entry output
// buffer, so req_stall rises only when both entries are full; it is a
// registered signal. Write the csr_ registers only while the block is idle.
module sync_framed_input_deframer #(
   parameter int COUNT_WIDTH = sfid_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_data_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [2:0]                            rsp_status,
   output logic [7:0]                            rsp_frame_type,
   output logic [15:0]                           rsp_frame_seq,
   output logic [7:0]                            rsp_payload_len,
   output logic [7:0]                            rsp_control_byte,
   output logic [sfid_pkg::OUT_COUNT_WIDTH-1:0]  rsp_good_count,
   output logic [sfid_pkg::OUT_COUNT_WIDTH-1:0]  rsp_error_count,
   input  logic                                  csr_write,
   input  logic [sfid_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [7:0]                            csr_data
);
   import sfid_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          take;
   frame_end_type frame_end;
   logic          result_valid;
   result_type    result;
   result_type    head_data;
   logic          queue_full;

   // Configuration registers; drop writes to unused indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:    cfg_in.sync_first    = csr_data;
            CSR_SYNC_SECOND:   cfg_in.sync_second   = csr_data;
            CSR_ACCEPTED_TYPE: cfg_in.accepted_type = csr_data;
            CSR_MIN_LENGTH:    cfg_in.min_length    = csr_data;
            CSR_MAX_LENGTH:    cfg_in.max_length    = csr_data;
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first    <= SYNC_FIRST_RESET;
         cfg_ff.sync_second   <= SYNC_SECOND_RESET;
         cfg_ff.accepted_type <= ACCEPTED_TYPE_RESET;
         cfg_ff.min_length    <= MIN_LENGTH_RESET;
         cfg_ff.max_length    <= MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold input while the output buffer has no free entry.
   assign req_stall = queue_full;
   assign take      = req_valid && !queue_full;

   sfid_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .cfg       (cfg_ff),
      .frame_end (frame_end)
   );

   // Decide status, advance sequence tracking and counters at frame end.
   sfid_judge #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_judge (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .frame_end    (frame_end),
      .result_valid (result_valid),
      .result       (result)
   );

   sfid_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .pop_stall  (rsp_stall),
      .head_valid (rsp_valid),
      .head_data  (head_data),
      .full       (queue_full)
   );

   assign rsp_status       = head_data.status;
   assign rsp_frame_type   = head_data.frame_type;
   assign rsp_frame_seq    = head_data.frame_seq;
   assign rsp_payload_len  = head_data.payload_len;
   assign rsp_control_byte = head_data.control_byte;
   assign rsp_good_count   = head_data.good_count;
   assign rsp_error_count  = head_data.error_count;

endmodule
